@@ rtl/core/potms_pkg.sv @@
package potms_pkg;

   localparam int unsigned CMD_W  = 3;
   localparam int unsigned MODE_W = 2;
   localparam int unsigned IVAL_W = 32;
   localparam int unsigned CNT_W  = 32;
   localparam int unsigned TIME_W = 64;
   localparam int unsigned MASK_W = 2;

   localparam logic [IVAL_W-1:0] MIN_INTERVAL = 32'd1;
   localparam logic [IVAL_W-1:0] MAX_INTERVAL = 32'd3600000000;

   // one quotient bit per step of the shared divider
   localparam int unsigned DIV_STEPS  = TIME_W;
   localparam int unsigned DIV_STEP_W = $clog2(DIV_STEPS);

   typedef enum logic [CMD_W-1:0] {
      CMD_CLEAR   = 3'd0,
      CMD_INIT    = 3'd1,
      CMD_START   = 3'd2,
      CMD_STOP    = 3'd3,
      CMD_SETCMP  = 3'd4,
      CMD_ADVANCE = 3'd5,
      CMD_STATS   = 3'd6
   } cmd_type;

   typedef enum logic [MODE_W-1:0] {
      MODE_PERIODIC = 2'd0,
      MODE_ONESHOT  = 2'd1
   } mode_type;

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_EXEC   = 6'b000010,
      S_CHECK  = 6'b000100,
      S_DIV    = 6'b001000,
      S_UPDATE = 6'b010000,
      S_RESP   = 6'b100000
   } state_type;

endpackage

@@ rtl/core/periodic_oneshot_timer_with_miss_stats.sv @@
// Compare timer bank on a 64-bit virtual microsecond clock that only moves on an advance
// command or a clear, which sets it to zero. Every command word gives exactly one response
// word. Clear, init, start, stop, set compare and read stats pass from acceptance through
// an execute state to the response state and out on rsp_valid. An advance also checks
// every timer in turn: each firing periodic timer folds its missed periods through one
// shared restoring divider over the time since expiry that yields one quotient bit per cycle,
// followed by an update step. One command is in flight at a time; req_ready is high
// only while the sequencer is idle, and a finished response waits in the output
// register until it is taken.
module periodic_oneshot_timer_with_miss_stats #(
   parameter int unsigned TIMER_COUNT = 2
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [potms_pkg::CMD_W-1:0]          req_command,
   input  logic                                 req_timer_index,
   input  logic [potms_pkg::MODE_W-1:0]         req_mode,
   input  logic [potms_pkg::IVAL_W-1:0]         req_interval_us,
   input  logic [potms_pkg::IVAL_W-1:0]         req_delta_us,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_status,
   output logic [potms_pkg::MASK_W-1:0]         rsp_expired_mask,
   output logic [potms_pkg::CNT_W-1:0]          rsp_expiry_count,
   output logic [potms_pkg::CNT_W-1:0]          rsp_miss_count,
   output logic                                 rsp_is_running,
   output logic [potms_pkg::TIME_W-1:0]         rsp_time_now
);
   import potms_pkg::*;

   localparam int unsigned IDX_W = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
   localparam logic [IDX_W-1:0] LAST_TIMER = IDX_W'(TIMER_COUNT - 1);

   state_type                 state_ff, state_in;
   logic [CMD_W-1:0]          cmd_ff, cmd_in;
   logic                      idx_ff, idx_in;
   logic [MODE_W-1:0]         mode_ff, mode_in;
   logic [IVAL_W-1:0]         ival_ff, ival_in;
   logic [IVAL_W-1:0]         delta_ff, delta_in;
   logic [IDX_W-1:0]          cur_ff, cur_in;
   logic [TIME_W-1:0]         time_ff, time_in;
   logic                      status_ff, status_in;
   logic [MASK_W-1:0]         mask_ff, mask_in;
   logic                      late_ff, late_in;
   logic [TIME_W-1:0]         dvd_ff, dvd_in;
   logic [IVAL_W-1:0]         rem_ff, rem_in;
   logic [DIV_STEP_W-1:0]     step_ff, step_in;

   logic                      run_ff [TIMER_COUNT];
   logic                      run_in [TIMER_COUNT];
   logic                      oneshot_ff [TIMER_COUNT];
   logic                      oneshot_in [TIMER_COUNT];
   logic [IVAL_W-1:0]         interval_ff [TIMER_COUNT];
   logic [IVAL_W-1:0]         interval_in [TIMER_COUNT];
   logic [TIME_W-1:0]         expiry_ff [TIMER_COUNT];
   logic [TIME_W-1:0]         expiry_in [TIMER_COUNT];
   logic [CNT_W-1:0]          irq_ff [TIMER_COUNT];
   logic [CNT_W-1:0]          irq_in [TIMER_COUNT];
   logic [CNT_W-1:0]          miss_ff [TIMER_COUNT];
   logic [CNT_W-1:0]          miss_in [TIMER_COUNT];

   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_status_ff, rsp_status_in;
   logic [MASK_W-1:0]         rsp_mask_ff, rsp_mask_in;
   logic [CNT_W-1:0]          rsp_irq_ff, rsp_irq_in;
   logic [CNT_W-1:0]          rsp_miss_ff, rsp_miss_in;
   logic                      rsp_run_ff, rsp_run_in;
   logic [TIME_W-1:0]         rsp_time_ff, rsp_time_in;

   logic                      idx_ok;
   logic [IDX_W-1:0]          tsel;
   logic                      ival_ok;
   logic [TIME_W-1:0]         cur_exp;
   logic [IVAL_W-1:0]         cur_iv;
   logic                      fire;
   logic                      late;
   logic                      last_timer;
   logic [IVAL_W:0]           rem_sh;
   logic                      div_ge;
   logic [IVAL_W:0]           div_sub;
   logic [IVAL_W:0]           step_gap;
   logic [TIME_W-1:0]         upd_exp;
   logic [CNT_W-1:0]          missed;

   assign idx_ok  = 32'(idx_ff) < TIMER_COUNT;
   assign tsel    = IDX_W'(idx_ff);
   assign ival_ok = (ival_ff >= MIN_INTERVAL) && (ival_ff <= MAX_INTERVAL);

   assign cur_exp    = expiry_ff[cur_ff];
   assign cur_iv     = interval_ff[cur_ff];
   assign fire       = run_ff[cur_ff] && (cur_iv != '0) && (time_ff >= cur_exp);
   assign late       = time_ff > (cur_exp + TIME_W'(1));
   assign last_timer = cur_ff == LAST_TIMER;

   // restoring divider step: shift in the next dividend bit, subtract if it fits
   assign rem_sh  = {rem_ff, dvd_ff[TIME_W-1]};
   assign div_ge  = rem_sh >= {1'b0, cur_iv};
   assign div_sub = rem_sh - {1'b0, cur_iv};

   // exp + (q+1)*iv equals now - rem + iv, and rem < iv
   assign step_gap = {1'b0, cur_iv} - {1'b0, rem_ff};
   assign upd_exp  = time_ff + TIME_W'(step_gap);
   assign missed   = dvd_ff[CNT_W-1:0] + CNT_W'(1);

   assign req_ready = state_ff == S_IDLE;

   always_comb begin
      state_in    = state_ff;
      cmd_in      = cmd_ff;
      idx_in      = idx_ff;
      mode_in     = mode_ff;
      ival_in     = ival_ff;
      delta_in    = delta_ff;
      cur_in      = cur_ff;
      time_in     = time_ff;
      status_in   = status_ff;
      mask_in     = mask_ff;
      late_in     = late_ff;
      dvd_in      = dvd_ff;
      rem_in      = rem_ff;
      step_in     = step_ff;
      run_in      = run_ff;
      oneshot_in  = oneshot_ff;
      interval_in = interval_ff;
      expiry_in   = expiry_ff;
      irq_in      = irq_ff;
      miss_in     = miss_ff;

      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_mask_in   = rsp_mask_ff;
      rsp_irq_in    = rsp_irq_ff;
      rsp_miss_in   = rsp_miss_ff;
      rsp_run_in    = rsp_run_ff;
      rsp_time_in   = rsp_time_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in    = req_command;
               idx_in    = req_timer_index;
               mode_in   = req_mode;
               ival_in   = req_interval_us;
               delta_in  = req_delta_us;
               status_in = 1'b0;
               mask_in   = '0;
               state_in  = S_EXEC;
            end
         end

         S_EXEC: begin
            state_in = S_RESP;
            unique case (cmd_ff)
               CMD_CLEAR: begin
                  time_in = '0;
                  for (int t = 0; t < TIMER_COUNT; t++) begin
                     run_in[t]      = 1'b0;
                     oneshot_in[t]  = 1'b0;
                     interval_in[t] = '0;
                     expiry_in[t]   = '0;
                     irq_in[t]      = '0;
                     miss_in[t]     = '0;
                  end
               end
               CMD_INIT: begin
                  if (idx_ok) begin
                     run_in[tsel]      = 1'b0;
                     oneshot_in[tsel]  = 1'b0;
                     interval_in[tsel] = '0;
                     expiry_in[tsel]   = '0;
                     irq_in[tsel]      = '0;
                     miss_in[tsel]     = '0;
                  end else begin
                     status_in = 1'b1;
                  end
               end
               CMD_START: begin
                  if (!idx_ok || !ival_ok ||
                      (mode_ff != MODE_PERIODIC && mode_ff != MODE_ONESHOT)) begin
                     status_in = 1'b1;
                  end else begin
                     oneshot_in[tsel]  = mode_ff == MODE_ONESHOT;
                     interval_in[tsel] = ival_ff;
                     expiry_in[tsel]   = time_ff + TIME_W'(ival_ff);
                     run_in[tsel]      = 1'b1;
                  end
               end
               CMD_STOP: begin
                  if (idx_ok) begin
                     run_in[tsel] = 1'b0;
                  end else begin
                     status_in = 1'b1;
                  end
               end
               CMD_SETCMP: begin
                  if (!idx_ok || !ival_ok) begin
                     status_in = 1'b1;
                  end else begin
                     interval_in[tsel] = ival_ff;
                     expiry_in[tsel]   = time_ff + TIME_W'(ival_ff);
                  end
               end
               CMD_ADVANCE: begin
                  time_in  = time_ff + TIME_W'(delta_ff);
                  cur_in   = '0;
                  state_in = S_CHECK;
               end
               CMD_STATS: begin
                  status_in = !idx_ok;
               end
               default: begin
                  status_in = 1'b1;
               end
            endcase
         end

         S_CHECK: begin
            late_in = late;
            if (fire && ((cur_ff >> 1) == IDX_W'(0))) begin
               mask_in[cur_ff[0]] = 1'b1;
            end
            if (fire && !oneshot_ff[cur_ff]) begin
               dvd_in   = time_ff - cur_exp;
               rem_in   = '0;
               step_in  = '0;
               state_in = S_DIV;
            end else begin
               if (fire) begin
                  irq_in[cur_ff] = irq_ff[cur_ff] + CNT_W'(1);
                  if (late) begin
                     miss_in[cur_ff] = miss_ff[cur_ff] + CNT_W'(1);
                  end
                  run_in[cur_ff] = 1'b0;
               end
               if (last_timer) begin
                  state_in = S_RESP;
               end else begin
                  cur_in = cur_ff + IDX_W'(1);
               end
            end
         end

         S_DIV: begin
            rem_in  = div_ge ? div_sub[IVAL_W-1:0] : rem_sh[IVAL_W-1:0];
            dvd_in  = {dvd_ff[TIME_W-2:0], div_ge};
            step_in = step_ff + DIV_STEP_W'(1);
            if (step_ff == DIV_STEP_W'(DIV_STEPS - 1)) begin
               state_in = S_UPDATE;
            end
         end

         S_UPDATE: begin
            expiry_in[cur_ff] = upd_exp;
            irq_in[cur_ff]    = irq_ff[cur_ff] + missed;
            if (late_ff) begin
               miss_in[cur_ff] = miss_ff[cur_ff] + missed;
            end
            if (last_timer) begin
               state_in = S_RESP;
            end else begin
               cur_in   = cur_ff + IDX_W'(1);
               state_in = S_CHECK;
            end
         end

         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_mask_in   = mask_ff;
               rsp_irq_in    = idx_ok ? irq_ff[tsel] : '0;
               rsp_miss_in   = idx_ok ? miss_ff[tsel] : '0;
               rsp_run_in    = idx_ok && run_ff[tsel];
               rsp_time_in   = time_ff;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         time_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int t = 0; t < TIMER_COUNT; t++) begin
            run_ff[t]      <= 1'b0;
            oneshot_ff[t]  <= 1'b0;
            interval_ff[t] <= '0;
            expiry_ff[t]   <= '0;
            irq_ff[t]      <= '0;
            miss_ff[t]     <= '0;
         end
      end else begin
         state_ff     <= state_in;
         time_ff      <= time_in;
         rsp_valid_ff <= rsp_valid_in;
         run_ff       <= run_in;
         oneshot_ff   <= oneshot_in;
         interval_ff  <= interval_in;
         expiry_ff    <= expiry_in;
         irq_ff       <= irq_in;
         miss_ff      <= miss_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      idx_ff        <= idx_in;
      mode_ff       <= mode_in;
      ival_ff       <= ival_in;
      delta_ff      <= delta_in;
      cur_ff        <= cur_in;
      status_ff     <= status_in;
      mask_ff       <= mask_in;
      late_ff       <= late_in;
      dvd_ff        <= dvd_in;
      rem_ff        <= rem_in;
      step_ff       <= step_in;
      rsp_status_ff <= rsp_status_in;
      rsp_mask_ff   <= rsp_mask_in;
      rsp_irq_ff    <= rsp_irq_in;
      rsp_miss_ff   <= rsp_miss_in;
      rsp_run_ff    <= rsp_run_in;
      rsp_time_ff   <= rsp_time_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_expired_mask = rsp_mask_ff;
   assign rsp_expiry_count = rsp_irq_ff;
   assign rsp_miss_count   = rsp_miss_ff;
   assign rsp_is_running   = rsp_run_ff;
   assign rsp_time_now     = rsp_time_ff;

endmodule

@@ rtl/core/potms_checker.sv @@
module potms_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_ready,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   input  logic                                 rsp_status,
   input  logic [potms_pkg::MASK_W-1:0]         rsp_expired_mask,
   input  logic [potms_pkg::TIME_W-1:0]         rsp_time_now
);
   import potms_pkg::*;

   // a word that is waiting keeps its time stamp
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_time_now))
      else $error("response word changed while stalled");

   // only one command in flight
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("command taken while another is in progress");

   // a rejected command never reports a firing
   a_err_no_fire: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> rsp_expired_mask == '0)
      else $error("expiry reported on an error response");

endmodule

bind periodic_oneshot_timer_with_miss_stats potms_checker u_potms_checker (.*);
